/* design/vdp_pkg.sv */
// Shared request codes and bit positions for the video display processor CPU port.
package vdp_pkg;

    typedef enum logic [2:0] {
        REQ_DATA_READ     = 3'd0,
        REQ_DATA_WRITE    = 3'd1,
        REQ_CONTROL_WRITE = 3'd2,
        REQ_STATUS_READ   = 3'd3,
        REQ_VBLANK_START  = 3'd4,
        REQ_FRAME_START   = 3'd5
    } req_type_t;

    localparam int NUM_CTRL_REGS = 8;

    // Second control byte: bit 7 selects a register write, bit 6 set skips the prefetch.
    localparam int CTRL_REG_WRITE_BIT   = 7;
    localparam int CTRL_NO_PREFETCH_BIT = 6;

    // Register 1 bit 5 enables the vblank interrupt.
    localparam logic [2:0] IRQ_CTRL_REG    = 3'd1;
    localparam int         IRQ_ENABLE_BIT  = 5;

    // Status bit 7 is the vblank flag.
    localparam int STATUS_VBLANK_BIT = 7;

    localparam logic [7:0] FILL_EVEN = 8'hff;
    localparam logic [7:0] FILL_ODD  = 8'h00;

endpackage

/* design/vdp_ram.sv */
// Generic single-port RAM with a registered read port.
module vdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* design/vdp_cpu_port_interface.sv */
// CPU port of a video display processor: VRAM, control registers, read-ahead and status.
// A result is registered: it is valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle unless a result stalls; the only loop is the VRAM port,
//   whose registered read data is consumed by the next read, so back-to-back reads never wait.
// Reset: control state clears at once, then a fill pass writes the VRAM pattern
//   (0xff even, 0x00 odd), one byte per cycle over all 2**VRAM_ADDR_BITS bytes, with req_ready low.
module vdp_cpu_port_interface #(
    parameter int VRAM_ADDR_BITS = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] req_type,
    input  logic [7:0] value,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [7:0] read_data,
    output logic       irq_level
);

    localparam int AW    = VRAM_ADDR_BITS;
    localparam int DEPTH = 1 << VRAM_ADDR_BITS;

    // Architectural state.
    logic [AW-1:0] addr_reg,        addr_next;
    logic [7:0]    ra_reg,          ra_next;
    // When set, the read-ahead byte is the RAM's registered read data rather than ra_reg.
    logic          ra_from_ram_reg, ra_from_ram_next;
    logic          latch_reg,       latch_next;
    logic [7:0]    status_reg,      status_next;
    logic          vblank_reg,      vblank_next;
    logic          irq_reg,         irq_next;
    logic [7:0]    ctrl_reg [vdp_pkg::NUM_CTRL_REGS];

    logic          ctrl_wr_en;
    logic [2:0]    ctrl_wr_idx;
    logic [7:0]    ctrl_wr_data;

    // Fill pass counter; its top bit marks the end of the pass.
    logic [AW:0]   fill_cnt_reg;
    logic          fill_done;

    // Result register.
    logic          rsp_valid_reg;
    logic [7:0]    rsp_data_reg,    rsp_data_next;
    logic          rsp_irq_reg;

    // VRAM port.
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic          accept;
    logic [7:0]    ra_cur;
    logic [15:0]   full_addr;
    logic [AW-1:0] set_addr;

    assign fill_done = fill_cnt_reg[AW];
    assign req_ready = fill_done && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign rsp_valid = rsp_valid_reg;
    assign read_data = rsp_data_reg;
    assign irq_level = rsp_irq_reg;

    assign ra_cur    = ra_from_ram_reg ? ram_rdata : ra_reg;

    // Address formed by a second control byte: high bits from the byte, low byte kept.
    assign full_addr = {value, addr_reg[7:0]};
    assign set_addr  = full_addr[AW-1:0];

    always_comb
    begin
        addr_next        = addr_reg;
        ra_next          = ra_reg;
        ra_from_ram_next = ra_from_ram_reg;
        latch_next       = latch_reg;
        status_next      = status_reg;
        vblank_next      = vblank_reg;
        irq_next         = irq_reg;
        rsp_data_next    = 8'h00;
        ctrl_wr_en       = 1'b0;
        ctrl_wr_idx      = value[2:0];
        ctrl_wr_data     = addr_reg[7:0];
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_addr         = addr_reg;
        ram_wdata        = value;

        if (!fill_done)
        begin
            // Fill pass owns the RAM port until it finishes.
            ram_we    = 1'b1;
            ram_addr  = fill_cnt_reg[AW-1:0];
            ram_wdata = fill_cnt_reg[0] ? vdp_pkg::FILL_ODD : vdp_pkg::FILL_EVEN;
        end
        else if (accept)
        begin
            unique case (vdp_pkg::req_type_t'(req_type))
                vdp_pkg::REQ_DATA_READ:
                begin
                    // Return the buffered byte and prefetch the one at the current address.
                    rsp_data_next    = ra_cur;
                    ram_re           = 1'b1;
                    ra_from_ram_next = 1'b1;
                    addr_next        = AW'(addr_reg + 1'b1);
                    latch_next       = 1'b0;
                end
                vdp_pkg::REQ_DATA_WRITE:
                begin
                    ram_we           = 1'b1;
                    ra_next          = value;
                    ra_from_ram_next = 1'b0;
                    addr_next        = AW'(addr_reg + 1'b1);
                    latch_next       = 1'b0;
                end
                vdp_pkg::REQ_CONTROL_WRITE:
                begin
                    latch_next = !latch_reg;
                    if (!latch_reg)
                    begin
                        addr_next = {addr_reg[AW-1:8], value};
                    end
                    else if (value[vdp_pkg::CTRL_REG_WRITE_BIT])
                    begin
                        // Register write; the data byte is the low address byte.
                        addr_next  = set_addr;
                        ctrl_wr_en = 1'b1;
                        if (value[2:0] == vdp_pkg::IRQ_CTRL_REG
                            && status_reg[vdp_pkg::STATUS_VBLANK_BIT])
                        begin
                            irq_next = addr_reg[vdp_pkg::IRQ_ENABLE_BIT];
                        end
                    end
                    else if (!value[vdp_pkg::CTRL_NO_PREFETCH_BIT])
                    begin
                        // Read setup: prefetch at the new address, then step past it.
                        ram_addr         = set_addr;
                        ram_re           = 1'b1;
                        ra_from_ram_next = 1'b1;
                        addr_next        = AW'(set_addr + 1'b1);
                    end
                    else
                    begin
                        addr_next = set_addr;
                    end
                end
                vdp_pkg::REQ_STATUS_READ:
                begin
                    rsp_data_next = status_reg;
                    latch_next    = 1'b0;
                    status_next   = 8'h00;
                    irq_next      = 1'b0;
                end
                vdp_pkg::REQ_VBLANK_START:
                begin
                    if (!vblank_reg)
                    begin
                        vblank_next = 1'b1;
                        status_next[vdp_pkg::STATUS_VBLANK_BIT] = 1'b1;
                        if (ctrl_reg[vdp_pkg::IRQ_CTRL_REG][vdp_pkg::IRQ_ENABLE_BIT])
                        begin
                            irq_next = 1'b1;
                        end
                    end
                end
                vdp_pkg::REQ_FRAME_START:
                begin
                    vblank_next = 1'b0;
                end
                default:
                begin
                    // Unused codes change nothing and return zero.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg        <= '0;
            ra_reg          <= 8'h00;
            ra_from_ram_reg <= 1'b0;
            latch_reg       <= 1'b0;
            status_reg      <= 8'h00;
            vblank_reg      <= 1'b0;
            irq_reg         <= 1'b0;
            ctrl_reg        <= '{default: 8'h00};
            fill_cnt_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_irq_reg     <= 1'b0;
        end
        else
        begin
            addr_reg        <= addr_next;
            ra_reg          <= ra_next;
            ra_from_ram_reg <= ra_from_ram_next;
            latch_reg       <= latch_next;
            status_reg      <= status_next;
            vblank_reg      <= vblank_next;
            irq_reg         <= irq_next;
            if (ctrl_wr_en)
            begin
                ctrl_reg[ctrl_wr_idx] <= ctrl_wr_data;
            end
            if (!fill_done)
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_irq_reg   <= irq_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The result byte is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    vdp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

/* design/vdp_cpu_port_checker.sv */
// Port-level assertions for the video display processor CPU port, bound to the top level.
module vdp_cpu_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [2:0] req_type,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_data,
    input logic       irq_level
);

    logic req_accept;

    assign req_accept = req_valid && req_ready;

    // A waiting result holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(irq_level))
        else $error("result changed or dropped while stalled");

    // Every accepted request yields a result in the next cycle.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> rsp_valid)
        else $error("accepted request produced no result");

    // A stalled result blocks new requests.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while result stalled");

    // A status read always drops the interrupt line.
    a_status_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && req_type == vdp_pkg::REQ_STATUS_READ |=> !irq_level)
        else $error("interrupt still high after status read");

    // Writes return no data.
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (req_type == vdp_pkg::REQ_DATA_WRITE
                       || req_type == vdp_pkg::REQ_CONTROL_WRITE) |=> read_data == 8'h00)
        else $error("write returned nonzero data");

endmodule

bind vdp_cpu_port_interface vdp_cpu_port_checker u_checker (.*);

/* verif/tb_vdp_cpu_port_interface.sv */
// Self-checking testbench for the video display processor CPU port: directed and random traffic.
`timescale 1ns / 1ps

module tb_vdp_cpu_port_interface;

    // The block is built with the default 16 KB video RAM.
    localparam int ADDR_BITS  = 14;
    localparam int VRAM_DEPTH = 1 << ADDR_BITS;

    // Request codes 6 and 7 have no function. They must return zero and change nothing.
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    // Each side idles in about this many cycles of a hundred, except during a quiet stretch.
    localparam int IDLE_PERCENT = 13;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
    } port_rsp_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    logic [2:0] req_type;
    logic [7:0] value;
    logic       rsp_valid;
    logic       rsp_ready;
    logic [7:0] read_data;
    logic       irq_level;

    // The predicted port state. It is updated once for each accepted request transaction.
    logic [7:0]           vram_m [VRAM_DEPTH];
    logic [7:0]           ctrl_m [vdp_pkg::NUM_CTRL_REGS];
    logic [ADDR_BITS-1:0] addr_m;
    logic [7:0]           read_ahead_m;
    logic                 second_byte_m;
    logic [7:0]           status_m;
    logic                 vblank_m;
    logic                 irq_m;

    // Predicted responses wait here until the block returns them, oldest first.
    port_rsp_t expected_rsp_q[$];

    int  error_count    = 0;
    int  rsp_checked    = 0;
    int  requests_sent  = 0;
    int  irq_seen       = 0;
    int  req_count [8];
    bit  quiet_stretch  = 1'b0;

    vdp_cpu_port_interface #(
        .VRAM_ADDR_BITS(ADDR_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .read_data (read_data),
        .irq_level (irq_level)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // This function decides for one cycle whether a side idles.
    // No side idles during a quiet stretch.
    function automatic bit idle_now();
        return !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // This task puts the predicted state in its reset condition.
    // The video RAM holds the fill pattern.
    task automatic reset_port_model();
        for (int i = 0; i < VRAM_DEPTH; i++)
        begin
            vram_m[i] = (i % 2 == 1) ? vdp_pkg::FILL_ODD : vdp_pkg::FILL_EVEN;
        end
        for (int i = 0; i < vdp_pkg::NUM_CTRL_REGS; i++)
        begin
            ctrl_m[i] = 8'h00;
        end
        addr_m        = '0;
        read_ahead_m  = 8'h00;
        second_byte_m = 1'b0;
        status_m      = 8'h00;
        vblank_m      = 1'b0;
        irq_m         = 1'b0;
    endtask

    // This function applies one request to the predicted state and returns the response
    // that it should give.
    function automatic port_rsp_t predict_port_rsp(input logic [2:0] kind,
                                                   input logic [7:0] data_in);
        port_rsp_t   rsp;
        logic [15:0] full_addr;
        logic [7:0]  low_byte;
        rsp.read_data = 8'h00;
        case (kind)
            vdp_pkg::REQ_DATA_READ:
            begin
                // The buffered byte goes out, and the byte at the current address replaces it.
                rsp.read_data = read_ahead_m;
                read_ahead_m  = vram_m[addr_m];
                addr_m        = addr_m + 1'b1;
                second_byte_m = 1'b0;
            end
            vdp_pkg::REQ_DATA_WRITE:
            begin
                vram_m[addr_m] = data_in;
                read_ahead_m   = data_in;
                addr_m         = addr_m + 1'b1;
                second_byte_m  = 1'b0;
            end
            vdp_pkg::REQ_CONTROL_WRITE:
            begin
                if (second_byte_m)
                begin
                    full_addr = {data_in, addr_m[7:0]};
                    addr_m    = full_addr[ADDR_BITS-1:0];
                    if (data_in[vdp_pkg::CTRL_REG_WRITE_BIT])
                    begin
                        // A register write uses the low address byte as its data. The address
                        // stays changed by the write.
                        low_byte = addr_m[7:0];
                        if (data_in[2:0] == vdp_pkg::IRQ_CTRL_REG
                            && status_m[vdp_pkg::STATUS_VBLANK_BIT])
                        begin
                            irq_m = low_byte[vdp_pkg::IRQ_ENABLE_BIT];
                        end
                        ctrl_m[data_in[2:0]] = low_byte;
                    end
                    else if (!data_in[vdp_pkg::CTRL_NO_PREFETCH_BIT])
                    begin
                        read_ahead_m = vram_m[addr_m];
                        addr_m       = addr_m + 1'b1;
                    end
                end
                else
                begin
                    addr_m[7:0] = data_in;
                end
                second_byte_m = !second_byte_m;
            end
            vdp_pkg::REQ_STATUS_READ:
            begin
                rsp.read_data = status_m;
                second_byte_m = 1'b0;
                status_m      = 8'h00;
                irq_m         = 1'b0;
            end
            vdp_pkg::REQ_VBLANK_START:
            begin
                if (!vblank_m)
                begin
                    vblank_m                             = 1'b1;
                    status_m[vdp_pkg::STATUS_VBLANK_BIT] = 1'b1;
                    if (ctrl_m[vdp_pkg::IRQ_CTRL_REG][vdp_pkg::IRQ_ENABLE_BIT])
                    begin
                        irq_m = 1'b1;
                    end
                end
            end
            vdp_pkg::REQ_FRAME_START:
            begin
                vblank_m = 1'b0;
            end
            default:
            begin
            end
        endcase
        rsp.irq_level = irq_m;
        return rsp;
    endfunction

    // This task sends one request transaction. It is called at a rising edge. It may idle first,
    // with junk on the payload, and then holds valid and the payload until the block accepts them.
    // Valid is not lowered after acceptance, so the next request can follow in the next cycle.
    task automatic issue_request(input logic [2:0] kind, input logic [7:0] data_in);
        while (idle_now())
        begin
            req_valid <= 1'b0;
            req_type  <= 3'($urandom_range(7));
            value     <= 8'($urandom);
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        value     <= data_in;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        expected_rsp_q.push_back(predict_port_rsp(kind, data_in));
        req_count[kind]++;
        requests_sent++;
    endtask

    // This task points the address at a VRAM location. The second byte either prefetches for
    // reads or skips the prefetch for writes.
    task automatic point_at(input logic [ADDR_BITS-1:0] addr, input bit for_read);
        logic [15:0] addr_wide;
        addr_wide = 16'(addr);
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, addr_wide[7:0]);
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, {1'b0, !for_read, addr_wide[13:8]});
    endtask

    // This task writes a control register. The unused bits of the second byte are random.
    task automatic write_ctrl_reg(input logic [2:0] index, input logic [7:0] data);
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, data);
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, {1'b1, 4'($urandom), index});
    endtask

    // The response side. Each response transaction is compared with the oldest prediction.
    // Ready is redrawn at every edge, so stalls land on every phase of the block's work.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("unexpected response: read_data %02h irq_level %0b", read_data, irq_level);
                error_count++;
            end
            else
            begin
                port_rsp_t exp_rsp;
                exp_rsp = expected_rsp_q.pop_front();
                rsp_checked++;
                if (read_data !== exp_rsp.read_data)
                begin
                    $error("read_data: expected %02h, actual %02h", exp_rsp.read_data, read_data);
                    error_count++;
                end
                if (irq_level !== exp_rsp.irq_level)
                begin
                    $error("irq_level: expected %0b, actual %0b", exp_rsp.irq_level, irq_level);
                    error_count++;
                end
                if (exp_rsp.irq_level)
                begin
                    irq_seen++;
                end
            end
        end
        rsp_ready <= !idle_now();
    end

    // Right after reset, the first read returns the empty buffer. The second read returns the
    // fill byte at address zero.
    task automatic test_read_ahead_after_reset();
        issue_request(vdp_pkg::REQ_DATA_READ, 8'h00);
        issue_request(vdp_pkg::REQ_DATA_READ, 8'hff);
    endtask

    // A write at the top address wraps the address to zero. A prefetch read at the top address
    // gets the byte back.
    task automatic test_address_wrap();
        point_at({ADDR_BITS{1'b1}}, 1'b0);
        issue_request(vdp_pkg::REQ_DATA_WRITE, 8'ha5);
        point_at({ADDR_BITS{1'b1}}, 1'b1);
        issue_request(vdp_pkg::REQ_DATA_READ, 8'h00);
    endtask

    // The vblank interrupt. It is enabled before vblank, and a second vblank start is ignored.
    // Register 1 is rewritten while the status flag is set, so the line drops and then rises.
    // A status read clears the flag, and a frame start ends the vblank.
    task automatic test_vblank_interrupt();
        write_ctrl_reg(vdp_pkg::IRQ_CTRL_REG, 8'h20);
        issue_request(vdp_pkg::REQ_VBLANK_START, 8'h00);
        issue_request(vdp_pkg::REQ_VBLANK_START, 8'h00);
        write_ctrl_reg(vdp_pkg::IRQ_CTRL_REG, 8'h00);
        write_ctrl_reg(vdp_pkg::IRQ_CTRL_REG, 8'h20);
        issue_request(vdp_pkg::REQ_STATUS_READ, 8'h00);
        issue_request(vdp_pkg::REQ_FRAME_START, 8'h00);
    endtask

    // A status read between the two control bytes clears the byte latch. The next control byte
    // is then taken as a first byte again.
    task automatic test_byte_latch_clear();
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, 8'h55);
        issue_request(vdp_pkg::REQ_STATUS_READ, 8'h00);
        write_ctrl_reg(3'd7, 8'haa);
    endtask

    // The spare codes, with all value bits set, must not disturb the latch or any other state.
    task automatic test_spare_codes();
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, 8'hff);
        issue_request(REQ_SPARE_6, 8'hff);
        issue_request(REQ_SPARE_7, 8'hff);
        issue_request(vdp_pkg::REQ_CONTROL_WRITE, 8'h80);
    endtask

    // Most of the random traffic is well-formed: an address setup followed by a burst of reads
    // or writes, register writes, and vblank handling. The rest is noise, such as lone control
    // bytes and spare codes. The high address byte often stays in a small window, so that reads
    // return bytes that were written earlier. One stretch of the run has no idling on either side.
    task automatic test_random_traffic();
        int                   start_count;
        int                   pick;
        int                   burst;
        logic [ADDR_BITS-1:0] addr;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS)
        begin
            quiet_stretch = (requests_sent - start_count) inside {[500:800]};
            pick  = $urandom_range(99);
            burst = $urandom_range(1, 8);
            addr  = ADDR_BITS'($urandom);
            if ($urandom_range(1) == 1)
            begin
                addr[ADDR_BITS-1:8] = '0;
                addr[9:8]           = 2'($urandom);
            end
            if (pick < 35)
            begin
                point_at(addr, 1'b1);
                repeat (burst)
                begin
                    issue_request(vdp_pkg::REQ_DATA_READ, 8'($urandom));
                end
            end
            else if (pick < 60)
            begin
                point_at(addr, 1'b0);
                repeat (burst)
                begin
                    issue_request(vdp_pkg::REQ_DATA_WRITE, 8'($urandom));
                end
            end
            else if (pick < 70)
            begin
                write_ctrl_reg(3'($urandom), 8'($urandom));
            end
            else if (pick < 80)
            begin
                case ($urandom_range(3))
                    0: write_ctrl_reg(vdp_pkg::IRQ_CTRL_REG, 8'($urandom));
                    1: issue_request(vdp_pkg::REQ_VBLANK_START, 8'($urandom));
                    2: issue_request(vdp_pkg::REQ_STATUS_READ, 8'($urandom));
                    default: issue_request(vdp_pkg::REQ_FRAME_START, 8'($urandom));
                endcase
            end
            else if (pick < 90)
            begin
                repeat (burst)
                begin
                    issue_request($urandom_range(1) ? vdp_pkg::REQ_DATA_READ
                                                    : vdp_pkg::REQ_DATA_WRITE,
                                  8'($urandom));
                end
            end
            else
            begin
                issue_request(3'($urandom_range(7)), 8'($urandom));
            end
        end
        quiet_stretch = 1'b0;
    endtask

    // The limit on the whole run. It covers the VRAM fill pass after reset many times over.
    initial
    begin
        #1_000_000;
        $display("** vdp_cpu_port_interface: FAILED **");
        $finish;
    end

    initial
    begin
        int drain_cycles;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_type  = vdp_pkg::REQ_DATA_READ;
        value     = 8'h00;
        rsp_ready = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            req_count[i] = 0;
        end
        reset_port_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block holds off requests during its VRAM fill pass. The first request waits on
        // ready like every other.
        test_read_ahead_after_reset();
        test_address_wrap();
        test_vblank_interrupt();
        test_byte_latch_clear();
        test_spare_codes();
        test_random_traffic();

        req_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_rsp_q.size() != 0 && drain_cycles < 10000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        // Extra waiting here catches any response that the block sends with no request behind it.
        repeat (8) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsp_q.size());
            error_count++;
        end

        $display("Sent %0d requests: %0d data reads, %0d data writes, %0d control bytes,",
                 requests_sent, req_count[vdp_pkg::REQ_DATA_READ],
                 req_count[vdp_pkg::REQ_DATA_WRITE], req_count[vdp_pkg::REQ_CONTROL_WRITE]);
        $display("  %0d status reads, %0d vblank starts; checked %0d responses, %0d with irq high.",
                 req_count[vdp_pkg::REQ_STATUS_READ], req_count[vdp_pkg::REQ_VBLANK_START],
                 rsp_checked, irq_seen);
        if (error_count == 0)
        begin
            $display("** vdp_cpu_port_interface: PASSED **");
        end
        else
        begin
            $display("** vdp_cpu_port_interface: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
design/vdp_pkg.sv
design/vdp_ram.sv
design/vdp_cpu_port_interface.sv
design/vdp_cpu_port_checker.sv
verif/tb_vdp_cpu_port_interface.sv
